// ===== hw/rtl/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 7;

   // request kinds; codes 6 and 7 are unknown and answered with a failing result
   typedef enum logic [KIND_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_CLEAR      = 3'd4,
      REQ_DUMP       = 3'd5
   } req_kind_type;

   // controller to datapath
   typedef struct packed {
      logic latch;   // request transaction taken, capture it and start the store read
      logic fire;    // execute and load one result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;   // output register can take a result this cycle
      logic run_last;    // result being formed is the last of its request
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_ram.sv =====
`default_nettype none

module bdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_ctrl.sv =====
`default_nettype none

module bdq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire bdq_pkg::status_type status,
   output bdq_pkg::cmd_type         cmd
);

   import bdq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.latch  = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.fire   = (state_ff == S_EXEC) && status.slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (status.slot_free && status.run_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_dpath.sv =====
`default_nettype none

module bdq_dpath #(
   parameter int DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [bdq_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [bdq_pkg::BYTE_W-1:0]  req_byte,
   input  wire bdq_pkg::cmd_type            cmd,
   output bdq_pkg::status_type              status,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic      [bdq_pkg::BYTE_W-1:0]  rsp_byte,
   output logic      [bdq_pkg::FILL_W-1:0]  rsp_fill,
   output logic                             rsp_empty,
   output logic                             rsp_last
);

   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // ring position: base + offset, both below DEPTH, so one subtract wraps it
   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
      return sum[AW-1:0];
   endfunction

   req_kind_type      kind_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [CW-1:0]     idx_ff;
   logic [CW-1:0]     idx_in;
   logic [AW-1:0]     head_ff;
   logic [AW-1:0]     head_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_ok_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [FILL_W-1:0] rsp_fill_ff;
   logic              rsp_empty_ff;
   logic              rsp_last_ff;

   logic              res_ok;
   logic [BYTE_W-1:0] res_byte;
   logic              res_last;
   logic [AW-1:0]     res_head;
   logic [CW-1:0]     res_count;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic              full;
   logic              empty;
   logic [CW-1:0]     idx_next;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign idx_next = idx_ff + CW'(1);

   // store read: at request capture for the front/back element, during a dump the next one
   always_comb begin
      rd_addr = head_ff;
      if (cmd.latch) begin
         if (req_kind == REQ_POP_BACK) rd_addr = ring_pos(head_ff, AW'(count_ff - CW'(1)));
      end else begin
         rd_addr = ring_pos(head_ff, AW'(idx_next));
      end
   end
   assign rd_en = cmd.latch | cmd.fire;

   always_comb begin
      res_ok    = 1'b0;
      res_byte  = '0;
      res_last  = 1'b1;
      res_head  = head_ff;
      res_count = count_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      unique case (kind_ff)
         REQ_PUSH_FRONT: begin
            if (!full) begin
               res_ok    = 1'b1;
               res_head  = ring_pos(head_ff, AW'(DEPTH - 1));
               res_count = count_ff + CW'(1);
               wr_en     = 1'b1;
               wr_addr   = ring_pos(head_ff, AW'(DEPTH - 1));
            end
         end
         REQ_PUSH_BACK: begin
            if (!full) begin
               res_ok    = 1'b1;
               res_count = count_ff + CW'(1);
               wr_en     = 1'b1;
               wr_addr   = ring_pos(head_ff, AW'(count_ff));
            end
         end
         REQ_POP_FRONT: begin
            if (!empty) begin
               res_ok    = 1'b1;
               res_byte  = rd_data;
               res_head  = ring_pos(head_ff, AW'(1));
               res_count = count_ff - CW'(1);
            end
         end
         REQ_POP_BACK: begin
            if (!empty) begin
               res_ok    = 1'b1;
               res_byte  = rd_data;
               res_count = count_ff - CW'(1);
            end
         end
         REQ_CLEAR: begin
            res_ok    = 1'b1;
            res_head  = '0;
            res_count = '0;
         end
         REQ_DUMP: begin
            if (!empty) begin
               res_ok   = 1'b1;
               res_byte = rd_data;
               res_last = (idx_next == count_ff);
            end
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.run_last  = res_last;

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.latch) idx_in = '0;
      if (cmd.fire) begin
         head_in      = res_head;
         count_in     = res_count;
         idx_in       = idx_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch) begin
         kind_ff <= req_kind_type'(req_kind);
         byte_ff <= req_byte;
      end
      if (cmd.fire) begin
         rsp_ok_ff    <= res_ok;
         rsp_byte_ff  <= res_byte;
         rsp_fill_ff  <= FILL_W'(res_count);
         rsp_empty_ff <= (res_count == '0);
         rsp_last_ff  <= res_last;
      end
   end

   bdq_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.fire && wr_en),
      .wr_addr (wr_addr),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_fill  = rsp_fill_ff;
   assign rsp_empty = rsp_empty_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_deque_ring.sv =====
// Bounded double-ended byte queue of DEPTH entries (2..64) held in a ring store
// addressed by a head pointer and an element count. A request transaction carries
// its kind in req_tuser (push front, push back, pop front, pop back, clear, dump)
// and the byte to push in req_tdata. Every request gives one response transaction,
// a dump of a non-empty queue gives one per stored byte, front to back, with tlast
// on the final one; an empty dump, a pop of an empty queue, a push onto a full queue
// and an unknown kind give ok = 0 and leave the queue as it was. fill_count and
// is_empty report the state after the request. A request is captured, then executed
// against the registered read of the single ring store, once per stored byte for a
// dump; an execute waits while the response register is full. req_tready is low from
// capture until the final response is loaded and comes back the cycle after. The
// response sits in an output register, so a new request is taken while the previous
// response waits. Ring store contents are not cleared at reset; no clearing pass is needed.

`default_nettype none

module byte_deque_ring #(
   parameter int DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] item_byte
   input  wire logic [2:0]  req_tuser,   // [2:0] req_type
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [0] ok, [8:1] out_byte, [15:9] fill_count,
                                         // [16] is_empty, [23:17] zero
   output logic             rsp_tlast    // last_of_run
);

   import bdq_pkg::*;

   cmd_type           cmd;
   status_type        status;

   logic              rsp_ok;
   logic [BYTE_W-1:0] rsp_byte;
   logic [FILL_W-1:0] rsp_fill;
   logic              rsp_empty;

   // sequencer: idle / execute, owns the request handshake
   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // head/count, ring store and the response register
   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_kind  (req_tuser),
      .req_byte  (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ok    (rsp_ok),
      .rsp_byte  (rsp_byte),
      .rsp_fill  (rsp_fill),
      .rsp_empty (rsp_empty),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_empty, rsp_fill, rsp_byte, rsp_ok};

endmodule

`default_nettype wire
